// ===== rtl/ubxfp_pkg.sv =====
// shared types, constants and message table for the ubx frame parser
package ubxfp_pkg;

    // sync pair and frame positions
    localparam logic [7:0] SYNC_1       = 8'hB5;
    localparam logic [7:0] SYNC_2       = 8'h62;
    localparam logic [7:0] POS_CLASS    = 8'd2;
    localparam logic [7:0] POS_LEN_LO   = 8'd4;
    localparam logic [7:0] POS_LEN_HI   = 8'd5;
    localparam logic [7:0] POS_PAYLOAD  = 8'd6;
    localparam logic [7:0] TRAILER_SPAN = 8'd7;

    // message classes
    localparam logic [7:0] CLS_NAV = 8'h01;
    localparam logic [7:0] CLS_CFG = 8'h06;

    // message ids
    localparam logic [7:0] ID_NAV_POSLLH = 8'h02;
    localparam logic [7:0] ID_NAV_STATUS = 8'h03;
    localparam logic [7:0] ID_NAV_SOL    = 8'h06;
    localparam logic [7:0] ID_NAV_VELNED = 8'h12;
    localparam logic [7:0] ID_NAV_DOP    = 8'h04;
    localparam logic [7:0] ID_CFG_PRT    = 8'h00;
    localparam logic [7:0] ID_CFG_RATE   = 8'h08;
    localparam logic [7:0] ID_CFG_MSG    = 8'h01;

    // fixed payload lengths
    localparam logic [7:0] LEN_NAV_POSLLH = 8'd28;
    localparam logic [7:0] LEN_NAV_STATUS = 8'd16;
    localparam logic [7:0] LEN_NAV_SOL    = 8'd52;
    localparam logic [7:0] LEN_NAV_VELNED = 8'd36;
    localparam logic [7:0] LEN_NAV_DOP    = 8'd18;
    localparam logic [7:0] LEN_CFG_PRT    = 8'd20;
    localparam logic [7:0] LEN_CFG_RATE   = 8'd6;
    localparam logic [7:0] LEN_CFG_MSG    = 8'd3;

    // event codes
    localparam logic EV_PAYLOAD = 1'b0;
    localparam logic EV_FINISH  = 1'b1;

    typedef enum logic [2:0] {
        KIND_POS     = 3'd0,
        KIND_STATUS  = 3'd1,
        KIND_SOL     = 3'd2,
        KIND_VELNED  = 3'd3,
        KIND_DOP     = 3'd4,
        KIND_CFG_PRT = 3'd5,
        KIND_CFG_RATE = 3'd6,
        KIND_CFG_MSG = 3'd7
    } msg_kind_t;

    typedef struct packed {
        logic       hit;
        msg_kind_t  kind;
        logic [7:0] len;
    } msg_info_t;

    // look up a class/id pair in the known message table
    function automatic msg_info_t lookup_msg(input logic [7:0] cls, input logic [7:0] id);
        msg_info_t info;
        info.hit  = 1'b1;
        info.kind = KIND_POS;
        info.len  = 8'd0;
        if (cls == CLS_NAV) begin
            case (id)
                ID_NAV_POSLLH: begin info.kind = KIND_POS;    info.len = LEN_NAV_POSLLH; end
                ID_NAV_STATUS: begin info.kind = KIND_STATUS; info.len = LEN_NAV_STATUS; end
                ID_NAV_SOL:    begin info.kind = KIND_SOL;    info.len = LEN_NAV_SOL;    end
                ID_NAV_VELNED: begin info.kind = KIND_VELNED; info.len = LEN_NAV_VELNED; end
                ID_NAV_DOP:    begin info.kind = KIND_DOP;    info.len = LEN_NAV_DOP;    end
                default:       info.hit = 1'b0;
            endcase
        end else if (cls == CLS_CFG) begin
            case (id)
                ID_CFG_PRT:  begin info.kind = KIND_CFG_PRT;  info.len = LEN_CFG_PRT;  end
                ID_CFG_RATE: begin info.kind = KIND_CFG_RATE; info.len = LEN_CFG_RATE; end
                ID_CFG_MSG:  begin info.kind = KIND_CFG_MSG;  info.len = LEN_CFG_MSG;  end
                default:     info.hit = 1'b0;
            endcase
        end else begin
            info.hit = 1'b0;
        end
        return info;
    endfunction

endpackage

// ===== rtl/ubx_frame_parser_core.sv =====
// ubx frame parser: sync hunt, header check, payload stream and fletcher-8 check
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  in      | in_valid, in_stall, byte_in                          | to block
//  out     | out_valid, out_stall, event_res, msg_kind,           | from block
//          | payload_index, payload_byte, checksum_ok             |
//
// one byte per cycle while no result is held; an accepted byte sits in the input
// register and the parser logic writes its result into the result register once
// that register is free, and the result register drives the output channel.
// reset clears the hunt state, sums and both valid flags; the header bytes
// are written before they are read and carry no reset.
// a held result stalls the parser stage, which in turn stalls the input once
// the input register is full; no transaction is lost or repeated.
module ubx_frame_parser_core
    import ubxfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       event_res,
    output logic [2:0] msg_kind,
    output logic [5:0] payload_index,
    output logic [7:0] payload_byte,
    output logic       checksum_ok
);

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;

    // parser state
    logic       in_frame_reg,  in_frame_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic [7:0] stop_pos_reg,  stop_pos_next;
    msg_kind_t  frame_kind_reg, frame_kind_next;
    logic [7:0] sum_a_reg,     sum_a_next;
    logic [7:0] sum_b_reg,     sum_b_next;
    logic [7:0] hdr_cls_reg,   hdr_cls_next;
    logic [7:0] hdr_id_reg,    hdr_id_next;
    logic [7:0] hdr_len_reg,   hdr_len_next;
    logic       ck_a_ok_reg,   ck_a_ok_next;

    // result register
    logic       out_valid_reg;
    logic       ev_reg;
    logic [2:0] kind_reg;
    logic [5:0] index_reg;
    logic [7:0] pbyte_reg;
    logic       ck_ok_reg;

    // parser outputs for this byte
    logic       emit;
    logic       ev_c;
    logic [5:0] index_c;
    logic [7:0] pbyte_c;
    logic       ck_ok_c;

    logic       out_free;
    logic       fire;
    logic [7:0] cnt_inc;
    logic [8:0] cnt_inc2;
    logic [7:0] add_a;
    logic [7:0] add_b;
    logic [7:0] idx_full;
    msg_info_t  info;

    // handshake between stages
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_byte_reg <= byte_in;
        end
    end

    // helper values
    assign cnt_inc  = byte_count_reg + 8'd1;
    assign cnt_inc2 = {1'b0, cnt_inc} + 9'd1;
    assign add_a    = sum_a_reg + s1_byte_reg;
    assign add_b    = sum_b_reg + add_a;
    assign idx_full = cnt_inc - POS_PAYLOAD;
    assign info     = lookup_msg(hdr_cls_reg, hdr_id_reg);

    // parser next state and result
    always_comb
    begin
        in_frame_next   = in_frame_reg;
        byte_count_next = byte_count_reg;
        stop_pos_next   = stop_pos_reg;
        frame_kind_next = frame_kind_reg;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        hdr_cls_next    = hdr_cls_reg;
        hdr_id_next     = hdr_id_reg;
        hdr_len_next    = hdr_len_reg;
        ck_a_ok_next    = ck_a_ok_reg;
        emit            = 1'b0;
        ev_c            = EV_PAYLOAD;
        index_c         = 6'd0;
        pbyte_c         = 8'd0;
        ck_ok_c         = 1'b0;
        if (!in_frame_reg)
        begin
            // hunting: sync 1 clears the count, sync 2 bumps it
            if (s1_byte_reg == SYNC_1)
            begin
                byte_count_next = 8'd0;
            end
            else if (s1_byte_reg == SYNC_2)
            begin
                byte_count_next = cnt_inc;
                if (cnt_inc == 8'd1)
                begin
                    in_frame_next = 1'b1;
                    sum_a_next    = 8'd0;
                    sum_b_next    = 8'd0;
                end
            end
        end
        else
        begin
            byte_count_next = cnt_inc;
            if (cnt_inc inside {[POS_CLASS:POS_LEN_LO]})
            begin
                // header bytes
                sum_a_next = add_a;
                sum_b_next = add_b;
                case (cnt_inc)
                    POS_CLASS:        hdr_cls_next = s1_byte_reg;
                    POS_LEN_LO:       hdr_len_next = s1_byte_reg;
                    default:          hdr_id_next  = s1_byte_reg;
                endcase
            end
            else if (cnt_inc == POS_LEN_HI)
            begin
                // length check against the table
                sum_a_next = add_a;
                sum_b_next = add_b;
                if (info.hit && hdr_len_reg == info.len && s1_byte_reg == 8'd0)
                begin
                    frame_kind_next = info.kind;
                    stop_pos_next   = info.len + TRAILER_SPAN;
                end
                else
                begin
                    in_frame_next = 1'b0;
                end
            end
            else if (cnt_inc == stop_pos_reg)
            begin
                // second check byte closes the frame
                in_frame_next = 1'b0;
                emit          = 1'b1;
                ev_c          = EV_FINISH;
                ck_ok_c       = ck_a_ok_reg && (s1_byte_reg == sum_b_reg);
            end
            else if (cnt_inc2 == {1'b0, stop_pos_reg})
            begin
                // first check byte
                ck_a_ok_next = (s1_byte_reg == sum_a_reg);
            end
            else if (cnt_inc >= POS_PAYLOAD && cnt_inc2 < {1'b0, stop_pos_reg})
            begin
                // payload byte
                sum_a_next = add_a;
                sum_b_next = add_b;
                emit       = 1'b1;
                ev_c       = EV_PAYLOAD;
                index_c    = idx_full[5:0];
                pbyte_c    = s1_byte_reg;
            end
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            byte_count_reg <= 8'd0;
            stop_pos_reg   <= 8'd0;
            frame_kind_reg <= KIND_POS;
            sum_a_reg      <= 8'd0;
            sum_b_reg      <= 8'd0;
            ck_a_ok_reg    <= 1'b0;
        end
        else if (fire)
        begin
            in_frame_reg   <= in_frame_next;
            byte_count_reg <= byte_count_next;
            stop_pos_reg   <= stop_pos_next;
            frame_kind_reg <= frame_kind_next;
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            ck_a_ok_reg    <= ck_a_ok_next;
        end
    end

    // header bytes, no reset
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            hdr_cls_reg <= hdr_cls_next;
            hdr_id_reg  <= hdr_id_next;
            hdr_len_reg <= hdr_len_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fire && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            ev_reg    <= ev_c;
            kind_reg  <= frame_kind_reg;
            index_reg <= index_c;
            pbyte_reg <= pbyte_c;
            ck_ok_reg <= ck_ok_c;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = ev_reg;
    assign msg_kind      = kind_reg;
    assign payload_index = index_reg;
    assign payload_byte  = pbyte_reg;
    assign checksum_ok   = ck_ok_reg;

    // count never runs past the stop position inside a frame
    a_count_below_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_frame_reg && byte_count_reg >= POS_PAYLOAD) |-> (byte_count_reg < stop_pos_reg))
        else $error("byte count past stop position");

    // a finished frame always returns to hunting
    a_finish_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && emit && ev_c == EV_FINISH) |=> !in_frame_reg)
        else $error("frame still open after finish transaction");

    // stop position only takes a known length plus trailer
    a_stop_known: assert property (@(posedge clk) disable iff (!rst_n)
        (stop_pos_reg == 8'd0) || (stop_pos_reg == 8'd35) || (stop_pos_reg == 8'd23) ||
        (stop_pos_reg == 8'd59) || (stop_pos_reg == 8'd43) || (stop_pos_reg == 8'd25) ||
        (stop_pos_reg == 8'd27) || (stop_pos_reg == 8'd13) || (stop_pos_reg == 8'd10))
        else $error("stop position not from message table");

    // a payload transaction never reports a checksum result
    a_payload_no_ck: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ev_reg == EV_PAYLOAD) |-> !ck_ok_reg)
        else $error("checksum flag set on payload transaction");

endmodule

// ===== sim/tb_ubx_frame_parser_core.sv =====
// testbench for the ubx frame parser: directed byte table, then random framed traffic
module tb_ubx_frame_parser_core
    import ubxfp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // one result event as seen on the output channel
    typedef struct packed {
        logic       ev;
        msg_kind_t  kind;
        logic [5:0] idx;
        logic [7:0] data;
        logic       ok;
    } parse_result_t;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct packed {
        logic [7:0]    data;
        logic          typed;
        logic          has_res;
        parse_result_t res;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] cls;
        logic [7:0] id;
        logic [7:0] len;
    } msg_entry_t;

    localparam parse_result_t NO_RES = '0;

    // lone sync after reset, good cfg-msg frame, ignored sync, unknown pair,
    // then a cfg-msg frame whose second check byte is wrong
    localparam dir_row_t DIRECTED_ROWS [28] = '{
        '{8'h62, 1'b1, 1'b0, NO_RES},
        '{8'h06, 1'b1, 1'b0, NO_RES},
        '{8'h01, 1'b1, 1'b0, NO_RES},
        '{8'h03, 1'b1, 1'b0, NO_RES},
        '{8'h00, 1'b1, 1'b0, NO_RES},
        '{8'h00, 1'b1, 1'b1, '{EV_PAYLOAD, KIND_CFG_MSG, 6'd0, 8'h00, 1'b0}},
        '{8'hFF, 1'b1, 1'b1, '{EV_PAYLOAD, KIND_CFG_MSG, 6'd1, 8'hFF, 1'b0}},
        '{8'h5A, 1'b1, 1'b1, '{EV_PAYLOAD, KIND_CFG_MSG, 6'd2, 8'h5A, 1'b0}},
        '{8'h63, 1'b0, 1'b0, NO_RES},
        '{8'h97, 1'b0, 1'b0, NO_RES},
        '{8'h62, 1'b1, 1'b0, NO_RES},
        '{8'hB5, 1'b1, 1'b0, NO_RES},
        '{8'h62, 1'b1, 1'b0, NO_RES},
        '{8'h01, 1'b1, 1'b0, NO_RES},
        '{8'h05, 1'b1, 1'b0, NO_RES},
        '{8'h10, 1'b1, 1'b0, NO_RES},
        '{8'h00, 1'b1, 1'b0, NO_RES},
        '{8'hB5, 1'b1, 1'b0, NO_RES},
        '{8'h62, 1'b1, 1'b0, NO_RES},
        '{8'h06, 1'b1, 1'b0, NO_RES},
        '{8'h01, 1'b1, 1'b0, NO_RES},
        '{8'h03, 1'b1, 1'b0, NO_RES},
        '{8'h00, 1'b1, 1'b0, NO_RES},
        '{8'hFF, 1'b1, 1'b1, '{EV_PAYLOAD, KIND_CFG_MSG, 6'd0, 8'hFF, 1'b0}},
        '{8'hFF, 1'b1, 1'b1, '{EV_PAYLOAD, KIND_CFG_MSG, 6'd1, 8'hFF, 1'b0}},
        '{8'hFF, 1'b1, 1'b1, '{EV_PAYLOAD, KIND_CFG_MSG, 6'd2, 8'hFF, 1'b0}},
        '{8'h07, 1'b1, 1'b0, NO_RES},
        '{8'h38, 1'b1, 1'b1, '{EV_FINISH, KIND_CFG_MSG, 6'd0, 8'h00, 1'b0}}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] byte_in = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       event_res;
    logic [2:0] msg_kind;
    logic [5:0] payload_index;
    logic [7:0] payload_byte;
    logic       checksum_ok;

    // parser state mirrored by the predictor
    bit         mdl_in_frame = 1'b0;
    logic [7:0] mdl_count = 8'd0;
    logic [7:0] mdl_stop = 8'd0;
    msg_kind_t  mdl_kind = KIND_POS;
    logic [7:0] mdl_sum_a = 8'd0;
    logic [7:0] mdl_sum_b = 8'd0;
    logic [7:0] mdl_hdr [3];
    bit         mdl_cka_ok = 1'b0;

    parse_result_t expected_events [$];
    int unsigned   mismatch_count = 0;
    int unsigned   bytes_sent = 0;
    bit            sender_steady = 1'b0;
    bit            receiver_steady = 1'b0;

    ubx_frame_parser_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .byte_in       (byte_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .msg_kind      (msg_kind),
        .payload_index (payload_index),
        .payload_byte  (payload_byte),
        .checksum_ok   (checksum_ok)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // class, id and payload length of each message kind
    function automatic msg_entry_t msg_entry(input logic [2:0] k);
        msg_entry_t e;
        case (k)
            KIND_POS:      e = '{CLS_NAV, ID_NAV_POSLLH, LEN_NAV_POSLLH};
            KIND_STATUS:   e = '{CLS_NAV, ID_NAV_STATUS, LEN_NAV_STATUS};
            KIND_SOL:      e = '{CLS_NAV, ID_NAV_SOL, LEN_NAV_SOL};
            KIND_VELNED:   e = '{CLS_NAV, ID_NAV_VELNED, LEN_NAV_VELNED};
            KIND_DOP:      e = '{CLS_NAV, ID_NAV_DOP, LEN_NAV_DOP};
            KIND_CFG_PRT:  e = '{CLS_CFG, ID_CFG_PRT, LEN_CFG_PRT};
            KIND_CFG_RATE: e = '{CLS_CFG, ID_CFG_RATE, LEN_CFG_RATE};
            default:       e = '{CLS_CFG, ID_CFG_MSG, LEN_CFG_MSG};
        endcase
        return e;
    endfunction

    // advance the parser state by one byte; returns 1 when an event is due
    function automatic bit predict_parse(input logic [7:0] b, output parse_result_t r);
        msg_entry_t e;
        bit         hit;
        msg_kind_t  k_found;
        logic [7:0] len_found;
        r = NO_RES;
        hit = 1'b0;
        k_found = KIND_POS;
        len_found = 8'd0;

        // hunting: only the sync bytes matter
        if (!mdl_in_frame)
        begin
            if (b == SYNC_1)
                mdl_count = 8'd0;
            else if (b == SYNC_2)
            begin
                mdl_count = mdl_count + 8'd1;
                if (mdl_count == 8'd1)
                begin
                    mdl_in_frame = 1'b1;
                    mdl_sum_a = 8'd0;
                    mdl_sum_b = 8'd0;
                end
            end
            return 1'b0;
        end

        mdl_count = mdl_count + 8'd1;

        // class, id, length low
        if (mdl_count >= POS_CLASS && mdl_count <= POS_LEN_LO)
        begin
            mdl_hdr[mdl_count - POS_CLASS] = b;
            mdl_sum_a = mdl_sum_a + b;
            mdl_sum_b = mdl_sum_b + mdl_sum_a;
            return 1'b0;
        end

        // length high: accept or drop the frame
        if (mdl_count == POS_LEN_HI)
        begin
            mdl_sum_a = mdl_sum_a + b;
            mdl_sum_b = mdl_sum_b + mdl_sum_a;
            for (int k = 0; k < 8; k++)
            begin
                e = msg_entry(k[2:0]);
                if (!hit && e.cls == mdl_hdr[0] && e.id == mdl_hdr[1])
                begin
                    hit = 1'b1;
                    k_found = msg_kind_t'(k[2:0]);
                    len_found = e.len;
                end
            end
            if (hit && mdl_hdr[2] == len_found && b == 8'd0)
            begin
                mdl_kind = k_found;
                mdl_stop = len_found + TRAILER_SPAN;
            end
            else
                mdl_in_frame = 1'b0;
            return 1'b0;
        end

        // second check byte closes the frame
        if (mdl_count == mdl_stop)
        begin
            mdl_in_frame = 1'b0;
            r = '{EV_FINISH, mdl_kind, 6'd0, 8'd0, mdl_cka_ok && b == mdl_sum_b};
            return 1'b1;
        end

        // first check byte
        if (mdl_count + 8'd1 == mdl_stop)
        begin
            mdl_cka_ok = (b == mdl_sum_a);
            return 1'b0;
        end

        // payload byte
        if (mdl_count >= POS_PAYLOAD && mdl_count + 8'd1 < mdl_stop)
        begin
            mdl_sum_a = mdl_sum_a + b;
            mdl_sum_b = mdl_sum_b + mdl_sum_a;
            r = '{EV_PAYLOAD, mdl_kind, 6'(mdl_count - POS_PAYLOAD), b, 1'b0};
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // send one byte after a random gap and record what it should produce
    task automatic send_row(input dir_row_t row);
        parse_result_t got;
        bit            has;
        int unsigned   gap;
        if ($urandom_range(0, 99) < 4)
            sender_steady = !sender_steady;
        gap = sender_steady ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= row.data;
        do @(posedge clk); while (in_stall);

        has = predict_parse(row.data, got);
        bytes_sent++;
        if (row.typed)
        begin
            if (row.has_res)
                expected_events.push_back(row.res);
        end
        else if (has)
            expected_events.push_back(got);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_row('{b, 1'b0, 1'b0, NO_RES});
    endtask

    // class through check bytes of one frame, optionally with a broken checksum
    task automatic send_body(input logic [2:0] k, input bit corrupt);
        msg_entry_t e;
        logic [7:0] body [$];
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        e = msg_entry(k);
        ck_a = 8'd0;
        ck_b = 8'd0;
        body = '{e.cls, e.id, e.len, 8'h00};
        repeat (e.len) body.push_back(8'($urandom_range(0, 255)));
        foreach (body[i])
        begin
            ck_a = ck_a + body[i];
            ck_b = ck_b + ck_a;
            send_byte(body[i]);
        end
        if (corrupt)
        begin
            case ($urandom_range(0, 2))
                0:       ck_a = ck_a ^ 8'($urandom_range(1, 255));
                1:       ck_b = ck_b ^ 8'($urandom_range(1, 255));
                default:
                begin
                    ck_a = ck_a ^ 8'($urandom_range(1, 255));
                    ck_b = ck_b ^ 8'($urandom_range(1, 255));
                end
            endcase
        end
        send_byte(ck_a);
        send_byte(ck_b);
    endtask

    // bad header: random class/id pair (which can still hit the table), wrong length, or high length set
    task automatic send_bad_header;
        msg_entry_t e;
        logic [7:0] cls;
        logic [7:0] id;
        logic [7:0] len_lo;
        logic [7:0] len_hi;
        e = msg_entry(3'($urandom_range(0, 7)));
        cls = e.cls;
        id = e.id;
        len_lo = e.len;
        len_hi = 8'h00;
        case ($urandom_range(0, 2))
            0:
            begin
                cls = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : cls;
                id = 8'($urandom_range(0, 19));
                len_lo = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) : len_lo;
            end
            1:       len_lo = e.len ^ 8'($urandom_range(1, 255));
            default: len_hi = 8'($urandom_range(1, 255));
        endcase
        send_byte(SYNC_1);
        send_byte(SYNC_2);
        send_byte(cls);
        send_byte(id);
        send_byte(len_lo);
        send_byte(len_hi);
    endtask

    // hold off the sender until every outstanding event has come out
    task automatic drain_events;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_events.size() != 0) @(posedge clk);
    endtask

    // output side stall pattern
    initial
    begin : result_stall
        int unsigned w;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 99) < 4)
                receiver_steady = !receiver_steady;
            w = receiver_steady ? 0 : $urandom_range(0, 17);
            if (w != 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // compare each accepted event with the oldest expectation
    always @(posedge clk)
    begin : check_events
        parse_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
            begin
                $error("event with none expected: event_res %0d msg_kind %0d index %0d byte %0h",
                       event_res, msg_kind, payload_index, payload_byte);
                mismatch_count++;
            end
            else
            begin
                want = expected_events.pop_front();
                if (event_res !== want.ev)
                begin
                    $error("event_res: expected %0d, actual %0d", want.ev, event_res);
                    mismatch_count++;
                end
                if (msg_kind !== want.kind)
                begin
                    $error("msg_kind: expected %0d, actual %0d", want.kind, msg_kind);
                    mismatch_count++;
                end
                if (payload_index !== want.idx)
                begin
                    $error("payload_index: expected %0d, actual %0d", want.idx, payload_index);
                    mismatch_count++;
                end
                if (payload_byte !== want.data)
                begin
                    $error("payload_byte: expected %0h, actual %0h", want.data, payload_byte);
                    mismatch_count++;
                end
                if (checksum_ok !== want.ok)
                begin
                    $error("checksum_ok: expected %0d, actual %0d", want.ok, checksum_ok);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin : stimulus
        int unsigned pick;
        int unsigned frames_done;
        frames_done = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (DIRECTED_ROWS[i])
            send_row(DIRECTED_ROWS[i]);

        // random traffic, mostly well-formed frames
        while (bytes_sent < 1100)
        begin
            pick = $urandom_range(0, 99);
            if (frames_done == 15 || pick < 2)
            begin
                // run of sync2 bytes until the wrapped count opens a frame
                while (!mdl_in_frame) send_byte(SYNC_2);
                send_body(3'($urandom_range(0, 7)), $urandom_range(0, 3) == 0);
            end
            else if (pick < 72)
            begin
                send_byte(SYNC_1);
                send_byte(SYNC_2);
                send_body(3'($urandom_range(0, 7)), $urandom_range(0, 3) == 0);
            end
            else if (pick < 86)
                send_bad_header;
            else
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            frames_done++;
            if (frames_done == 10 || $urandom_range(0, 39) == 0)
                drain_events;
        end

        drain_events;
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
